// ===== hdl/gbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Greedy box suppression package
// Shared constants and types for the box suppression block.
// ----------------------------------------------------------------------------
package gbs_pkg;

  localparam int unsigned MAX_KEPT = 64;
  localparam int unsigned ADDR_W   = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int unsigned CNT_W    = $clog2(MAX_KEPT + 1);
  localparam int unsigned POS_W    = 12;
  localparam int unsigned THR_W    = 9;
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned SIZE_W   = 15;
  localparam int unsigned AREA_W   = 2 * SIZE_W;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(179);

  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic [SIZE_W-1:0]         width;
    logic [SIZE_W-1:0]         height;
  } box_t;

  typedef struct packed {
    box_t              box;
    logic [AREA_W-1:0] area;
  } kept_entry_t;

  localparam int unsigned ENTRY_W = $bits(kept_entry_t);

  typedef struct packed {
    logic              clear;
    logic              rd_issue;
    box_t              cur_box;
    logic [AREA_W-1:0] cur_area;
    logic [THR_W-1:0]  threshold;
  } iou_ctrl_t;

endpackage

// ===== hdl/greedy_box_suppression.sv =====
// ----------------------------------------------------------------------------
// Greedy box suppression
// Greedy non-maximum suppression over score-sorted boxes with a kept store.
// ----------------------------------------------------------------------------
// A box request is taken when start_i is high while busy_o is low. The box is
// tested against every kept box of the current set, one stored box per cycle
// through a pipelined overlap unit. The result is shown after the area step,
// the scan of the store and the drain of the overlap pipeline; with an empty
// store the scan is skipped. busy_o drops in the cycle the result is
// shown, and the next request can be accepted at the end of that cycle. The
// result appears for exactly one cycle with result_valid_o high; the receiver
// cannot stall it and must take it then. A box with end_of_set_i closes the
// set and empties the store after its result.
module greedy_box_suppression (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [gbs_pkg::THR_W-1:0]   cfg_wdata_i,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic signed [15:0]          box_left_i,
  input  logic signed [15:0]          box_top_i,
  input  logic [14:0]                 box_width_i,
  input  logic [14:0]                 box_height_i,
  input  logic                        end_of_set_i,
  output logic                        result_valid_o,
  output logic                        keep_o,
  output logic [11:0]                 box_index_o,
  output logic                        store_full_o,
  output logic                        set_done_o
);
  import gbs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_AREA,
    ST_SCAN,
    ST_DRAIN
  } state_e;

  state_e            state_q;
  logic [THR_W-1:0]  thr_q;
  box_t              box_q;
  logic              last_q;
  logic [AREA_W-1:0] area_q;
  logic [CNT_W-1:0]  count_q, idx_q;
  logic [POS_W-1:0]  pos_q;
  logic              valid_q, keep_q, full_q, done_q;
  logic [POS_W-1:0]  index_q;

  iou_ctrl_t         ctrl;
  logic              hit, unit_busy, finish, room, wr_en;
  kept_entry_t       wr_entry;
  logic [ENTRY_W-1:0] rd_data;

  assign finish = (state_q == ST_DRAIN) && !unit_busy;
  assign room   = count_q < CNT_W'(MAX_KEPT);
  assign wr_en  = finish && !hit && room;

  always_comb begin
    ctrl.clear     = (state_q == ST_AREA);
    ctrl.rd_issue  = (state_q == ST_SCAN);
    ctrl.cur_box   = box_q;
    ctrl.cur_area  = area_q;
    ctrl.threshold = thr_q;
    wr_entry.box   = box_q;
    wr_entry.area  = area_q;
  end

  gbs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_KEPT)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i (ENTRY_W'(wr_entry)),
    .raddr_i (idx_q[ADDR_W-1:0]),
    .rdata_o (rd_data)
  );

  gbs_iou_unit u_iou (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .kept_i (rd_data),
    .hit_o  (hit),
    .busy_o (unit_busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      thr_q   <= THR_RESET;
      count_q <= '0;
      idx_q   <= '0;
      pos_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            state_q <= ST_AREA;
          end
        end
        ST_AREA: begin
          idx_q   <= '0;
          state_q <= (count_q != '0) ? ST_SCAN : ST_DRAIN;
        end
        ST_SCAN: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == count_q - 1'b1) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!unit_busy) begin
            valid_q <= 1'b1;
            state_q <= ST_IDLE;
            if (last_q) begin
              count_q <= '0;
              pos_q   <= '0;
            end else begin
              pos_q <= pos_q + 1'b1;
              if (wr_en) begin
                count_q <= count_q + 1'b1;
              end
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      box_q.left   <= box_left_i;
      box_q.top    <= box_top_i;
      box_q.width  <= box_width_i;
      box_q.height <= box_height_i;
      last_q       <= end_of_set_i;
    end
    if (state_q == ST_AREA) begin
      area_q <= box_q.width * box_q.height;
    end
    if (finish) begin
      keep_q  <= !hit;
      full_q  <= !hit && !room;
      done_q  <= last_q;
      index_q <= pos_q;
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = valid_q;
  assign keep_o         = keep_q;
  assign box_index_o    = index_q;
  assign store_full_o   = full_q;
  assign set_done_o     = done_q;

endmodule

// ===== hdl/gbs_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module gbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/gbs_iou_unit.sv =====
// ----------------------------------------------------------------------------
// Overlap test unit
// Pipelined intersection-over-union test of the current box against one
// stored box per cycle; collects a sticky suppression flag.
// ----------------------------------------------------------------------------
module gbs_iou_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gbs_pkg::iou_ctrl_t          ctrl_i,
  input  logic [gbs_pkg::ENTRY_W-1:0] kept_i,
  output logic                        hit_o,
  output logic                        busy_o
);
  import gbs_pkg::*;

  localparam int unsigned EDGE_W = COORD_W + 2;
  localparam int unsigned DIFF_W = EDGE_W + 1;
  localparam int unsigned UNI_W  = AREA_W + 1;
  localparam int unsigned LHS_W  = AREA_W + 8;
  localparam int unsigned RHS_W  = UNI_W + THR_W;

  kept_entry_t kept;
  logic signed [EDGE_W-1:0] a_l, a_t, a_r, a_b, b_l, b_t, b_r, b_b;
  logic signed [EDGE_W-1:0] x0, y0, x1, y1;
  logic signed [DIFF_W-1:0] dx_full, dy_full;
  logic [SIZE_W-1:0]        dx_d, dy_d;

  logic                     v0_q, v1_q, v2_q, v3_q, v4_q, hit_q;
  logic [SIZE_W-1:0]        dx_q, dy_q;
  logic [AREA_W-1:0]        karea1_q, karea2_q, inter2_q, inter3_q, inter4_q;
  logic [UNI_W-1:0]         uni3_q;
  logic [RHS_W-1:0]         rhs4_q;
  logic [LHS_W-1:0]         lhs;

  assign kept = kept_entry_t'(kept_i);

  always_comb begin
    a_l = EDGE_W'(ctrl_i.cur_box.left);
    a_t = EDGE_W'(ctrl_i.cur_box.top);
    a_r = a_l + $signed({3'b000, ctrl_i.cur_box.width});
    a_b = a_t + $signed({3'b000, ctrl_i.cur_box.height});
    b_l = EDGE_W'(kept.box.left);
    b_t = EDGE_W'(kept.box.top);
    b_r = b_l + $signed({3'b000, kept.box.width});
    b_b = b_t + $signed({3'b000, kept.box.height});
    x0 = (a_l > b_l) ? a_l : b_l;
    y0 = (a_t > b_t) ? a_t : b_t;
    x1 = (a_r < b_r) ? a_r : b_r;
    y1 = (a_b < b_b) ? a_b : b_b;
    dx_full = DIFF_W'(x1) - DIFF_W'(x0);
    dy_full = DIFF_W'(y1) - DIFF_W'(y0);
    dx_d = (dx_full > 0) ? dx_full[SIZE_W-1:0] : '0;
    dy_d = (dy_full > 0) ? dy_full[SIZE_W-1:0] : '0;
    lhs  = {inter4_q, 8'h00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q  <= 1'b0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      v0_q <= ctrl_i.rd_issue;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      if (ctrl_i.clear) begin
        hit_q <= 1'b0;
      end else if (v4_q && (LHS_W + 2)'(lhs) > (LHS_W + 2)'(rhs4_q)) begin
        hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    karea1_q <= kept.area;
    inter2_q <= dx_q * dy_q;
    karea2_q <= karea1_q;
    uni3_q   <= UNI_W'(ctrl_i.cur_area) + UNI_W'(karea2_q) - UNI_W'(inter2_q);
    inter3_q <= inter2_q;
    rhs4_q   <= RHS_W'(ctrl_i.threshold) * RHS_W'(uni3_q);
    inter4_q <= inter3_q;
  end

  assign hit_o  = hit_q;
  assign busy_o = v0_q | v1_q | v2_q | v3_q | v4_q;

endmodule
